### sv/vector_matrix_transform_4x4_unit_macros.svh
// assertion macros for the 4x4 vector-matrix transform unit
// used by modules that sample on clk and reset on rst_n (active low)
`ifndef VECTOR_MATRIX_TRANSFORM_4X4_UNIT_MACROS_SVH
`define VECTOR_MATRIX_TRANSFORM_4X4_UNIT_MACROS_SVH

// condition that must hold at every sampled edge out of reset
`define VMT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent this cycle implies consequent in the same cycle
`define VMT_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent this cycle implies consequent in the next cycle
`define VMT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/vmt_pkg.sv
// shared types, constants and the shift/saturate helper of the transform unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vmt_pkg;

    // element format: signed fixed point, Q16.16 by default
    localparam int ELEM_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // matrix geometry
    localparam int MAT_N     = 4;
    localparam int MAT_ELEMS = MAT_N * MAT_N;
    localparam int IDX_W     = $clog2(MAT_ELEMS);

    // exact product and exact sum of MAT_N products
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int SUM_W  = PROD_W + $clog2(MAT_N);

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;

    // item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_XFORM = 1'b1;

    // extreme values of the element range
    localparam elem_t ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    // identity diagonal value
    localparam elem_t ELEM_ONE = elem_t'(1) <<< FRAC_BITS;

    typedef struct packed {
        logic  sat;
        elem_t value;
    } fin_t;

    // arithmetic shift right by FRAC_BITS, then saturate to the element range
    function automatic fin_t finish_sum(input sum_t s);
        fin_t r;
        logic [SUM_W-FRAC_BITS-ELEM_WIDTH:0] top;
        top = s[SUM_W-1:FRAC_BITS+ELEM_WIDTH-1];
        if ((&top) || !(|top))
        begin
            r.sat   = 1'b0;
            r.value = s[FRAC_BITS+ELEM_WIDTH-1:FRAC_BITS];
        end
        else
        begin
            r.sat   = 1'b1;
            r.value = s[SUM_W-1] ? ELEM_MIN : ELEM_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/vector_matrix_transform_4x4_unit.sv
// Row vector by 4x4 matrix transform unit, signed Q16.16 fixed point.
// Input beats either load one matrix element (func = 0, elem_index row-major,
// elem_value) or transform a vector (func = 1, vec_x..vec_w). A load gives
// no output beat; a transform gives one beat with out_x..out_w and sat_flag.
// Both channels use valid/stall: a beat moves at a clock edge where valid
// is high and stall is low.
// Structure: an input register stage, then sixteen parallel 32x32 multiplies,
// four four-way sums, shift by 16 and saturation feeding the output register.
// A transform moves from the input register to the output register once the output register is free.
// Throughput: one beat per cycle while the receiver does not stall, loads and transforms in any mix; the rate
// is set by the single multiply/sum pass between the two registers.
// Matrix loads take effect in beat order: a transform sees every load
// accepted before it and none after it.
// Reset (rst_n low, asynchronous) empties both stages and sets the matrix
// to identity (1.0 on the diagonal).
// When the receiver stalls, the output beat holds; the input stage keeps
// taking beats until it holds a transform that cannot move, then in_stall
// rises. Loads never wait on the output side.
`timescale 1ns / 1ps
`default_nettype none

module vector_matrix_transform_4x4_unit
(
    input  wire logic            clk,
    input  wire logic            rst_n,

    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic            func,
    input  wire vmt_pkg::idx_t   elem_index,
    input  wire vmt_pkg::elem_t  elem_value,
    input  wire vmt_pkg::elem_t  vec_x,
    input  wire vmt_pkg::elem_t  vec_y,
    input  wire vmt_pkg::elem_t  vec_z,
    input  wire vmt_pkg::elem_t  vec_w,

    output logic                 out_valid,
    input  wire logic            out_stall,
    output vmt_pkg::elem_t       out_x,
    output vmt_pkg::elem_t       out_y,
    output vmt_pkg::elem_t       out_z,
    output vmt_pkg::elem_t       out_w,
    output logic                 sat_flag
);

    import vmt_pkg::*;

    `include "vector_matrix_transform_4x4_unit_macros.svh"

    // input stage
    logic  s1_valid_reg;
    logic  s1_valid_next;
    logic  s1_func_reg;
    idx_t  s1_idx_reg;
    elem_t s1_value_reg;
    elem_t s1_vec_reg [MAT_N];

    // stored matrix, row-major
    elem_t matrix_reg [MAT_ELEMS];

    // output stage
    logic  out_valid_reg;
    logic  out_valid_next;
    elem_t out_comp_reg  [MAT_N];
    elem_t out_comp_next [MAT_N];
    logic  sat_reg;
    logic  sat_next;

    // handshake
    logic in_fire;
    logic s1_is_load;
    logic s1_is_xform;
    logic out_free;
    logic s1_adv;
    logic out_load;

    // datapath
    prod_t prod [MAT_N][MAT_N];
    sum_t  col_sum [MAT_N];
    fin_t  col_fin [MAT_N];

    // output component at a range limit
    logic out_clamped;

    // stage movement
    always_comb
    begin
        s1_is_load  = s1_valid_reg && (s1_func_reg == FUNC_LOAD);
        s1_is_xform = s1_valid_reg && (s1_func_reg == FUNC_XFORM);
        out_free    = !out_valid_reg || !out_stall;
        s1_adv      = s1_is_load || (s1_is_xform && out_free);
        out_load    = s1_is_xform && out_free;
        in_stall    = s1_valid_reg && !s1_adv;
        in_fire     = in_valid && !in_stall;
    end

    // valid bits of both stages
    always_comb
    begin
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // products, column sums, shift and saturate
    always_comb
    begin
        sat_next = 1'b0;
        for (int c = 0; c < MAT_N; c++)
        begin
            col_sum[c] = '0;
            for (int r = 0; r < MAT_N; r++)
            begin
                prod[r][c] = prod_t'(s1_vec_reg[r]) * prod_t'(matrix_reg[r*MAT_N + c]);
                col_sum[c] = col_sum[c] + sum_t'(prod[r][c]);
            end
            col_fin[c]       = finish_sum(col_sum[c]);
            out_comp_next[c] = col_fin[c].value;
            sat_next         = sat_next | col_fin[c].sat;
        end
    end

    // control registers and matrix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAT_ELEMS; i++)
            begin
                matrix_reg[i] <= (i % (MAT_N + 1) == 0) ? ELEM_ONE : '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_is_load)
            begin
                matrix_reg[s1_idx_reg] <= s1_value_reg;
            end
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg   <= func;
            s1_idx_reg    <= elem_index;
            s1_value_reg  <= elem_value;
            s1_vec_reg[0] <= vec_x;
            s1_vec_reg[1] <= vec_y;
            s1_vec_reg[2] <= vec_z;
            s1_vec_reg[3] <= vec_w;
        end
    end

    // output stage payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_comp_reg <= out_comp_next;
            sat_reg      <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_comp_reg[0];
    assign out_y     = out_comp_reg[1];
    assign out_z     = out_comp_reg[2];
    assign out_w     = out_comp_reg[3];
    assign sat_flag  = sat_reg;

    // any output component sitting at the top or bottom of the range
    always_comb
    begin
        out_clamped = 1'b0;
        for (int c = 0; c < MAT_N; c++)
        begin
            out_clamped = out_clamped || (out_comp_reg[c] == ELEM_MAX)
                                      || (out_comp_reg[c] == ELEM_MIN);
        end
    end

    // checks
    `VMT_ASSERT_SAME(a_load_never_blocks, s1_is_load, !in_stall, "load beat held in input stage")
    `VMT_ASSERT_NEXT(a_xform_reaches_out, out_load, out_valid_reg, "transform lost before output")
    `VMT_ASSERT_SAME(a_stall_needs_xform, in_stall, s1_is_xform, "stall with no transform held")
    `VMT_ASSERT_SAME(a_sat_extreme, out_valid_reg && sat_reg, out_clamped, "flag without clamp")

endmodule

`default_nettype wire
